### sv/rwlt_pkg.sv
// shared types and constants for the reader-writer lock table
`timescale 1ns / 1ps
package rwlt_pkg;

	localparam int NUM_LOCKS_DEF = 16;
	localparam int NUM_PROCS_DEF = 16;

	// operation codes
	localparam logic [2:0] FN_CREATE = 3'd0;
	localparam logic [2:0] FN_DEL    = 3'd1;
	localparam logic [2:0] FN_RST    = 3'd2;
	localparam logic [2:0] FN_RD     = 3'd3;
	localparam logic [2:0] FN_WR     = 3'd4;
	localparam logic [2:0] FN_REL    = 3'd5;

	// process roles
	localparam logic [1:0] ROLE_NONE  = 2'd0;
	localparam logic [1:0] ROLE_READ  = 2'd1;
	localparam logic [1:0] ROLE_WRITE = 2'd3;

	// grant codes
	localparam logic [1:0] GR_NA    = 2'd0;
	localparam logic [1:0] GR_ENTER = 2'd1;
	localparam logic [1:0] GR_QUEUE = 2'd2;

	localparam logic signed [5:0] CNT_MAX = 6'sd31;
	localparam logic signed [5:0] CNT_MIN = 6'sb100000;

	typedef struct packed {
		logic signed [5:0] cnt;
		logic [3:0] head;
		logic [3:0] tail;
		logic [4:0] wc;
	} lock_t;

	typedef struct packed {
		logic [1:0] role;
		logic [3:0] nxt;
	} proc_t;

	localparam int LOCK_W = $bits(lock_t);
	localparam int PROC_W = $bits(proc_t);

	function automatic logic signed [5:0] cnt_step(input logic signed [5:0] c, input logic up);
		logic signed [5:0] r;
		if (up) begin
			r = (c == CNT_MAX) ? c : c + 6'sd1;
		end else begin
			r = (c == CNT_MIN) ? c : c - 6'sd1;
		end
		return r;
	endfunction

endpackage

### sv/rwlt_ram.sv
// generic single-write, single-read synchronous ram with registered read
`timescale 1ns / 1ps
module rwlt_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16,
	parameter int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic             re,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

### sv/reader_writer_lock_table.sv
// create probes one slot per cycle from the cursor; the wake and drain runs follow the
// wait list through the process ram, one read per cycle while the result output is free
// throughput: one operation at a time, next transfer taken once the final result is registered
// reset: arst_n clears all locks to free, all roles to none and the cursor to zero at once
`timescale 1ns / 1ps
module reader_writer_lock_table #(
	parameter int NUM_LOCKS = rwlt_pkg::NUM_LOCKS_DEF,
	parameter int NUM_PROCS = rwlt_pkg::NUM_PROCS_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [15:0] s_tdata,  // lock_id, pid, init_count
	input  logic [2:0]  s_tuser,  // func
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [15:0] m_tdata,  // status, grant, created_id, woken_pid
	output logic        m_tuser,  // woken_valid
	output logic        m_tlast
);

	localparam int LW = (NUM_LOCKS > 1) ? $clog2(NUM_LOCKS) : 1;
	localparam int PW = (NUM_PROCS > 1) ? $clog2(NUM_PROCS) : 1;
	localparam int QCAP = (NUM_PROCS < 16) ? NUM_PROCS : 16;

	typedef enum logic [8:0] {
		S_IDLE   = 9'b000000001,
		S_RD     = 9'b000000010,
		S_SCAN   = 9'b000000100,
		S_ENQ_RD = 9'b000001000,
		S_ENQ_WR = 9'b000010000,
		S_HD_RD  = 9'b000100000,
		S_WAKE   = 9'b001000000,
		S_DRAIN  = 9'b010000000,
		S_FIN    = 9'b100000000
	} state_t;

	state_t state_q;

	logic [2:0] func_q;
	logic [3:0] pid_q;
	logic [4:0] ic_q;
	logic [LW-1:0] lidx_q;
	logic lid_ok_q;
	rwlt_pkg::lock_t lk_q;
	logic [3:0] otail_q;
	logic st_q;
	logic [1:0] gr_q;
	logic [3:0] cid_q;
	logic pend_v_q;
	logic [3:0] pend_q;
	logic first_q;
	logic lkwr_q;
	logic [NUM_LOCKS-1:0] in_use_q;
	logic [NUM_PROCS-1:0] pv_q;
	logic [LW-1:0] cur_q;
	logic [LW:0] scan_q;
	logic prv_s1;

	logic ov_q, od_st_q, od_wv_q, od_last_q;
	logic [1:0] od_gr_q;
	logic [3:0] od_cid_q, od_wp_q;

	// ram ports
	logic lre, lwe, pre, pwe;
	logic [LW-1:0] lraddr;
	logic [PW-1:0] praddr, pwaddr;
	logic [rwlt_pkg::LOCK_W-1:0] lrdata, lwdata_w;
	logic [rwlt_pkg::PROC_W-1:0] prdata;
	rwlt_pkg::proc_t pwdata;
	rwlt_pkg::lock_t lk_rd, lwdata;
	rwlt_pkg::proc_t pr_eff;

	rwlt_ram #(.WIDTH(rwlt_pkg::LOCK_W), .DEPTH(NUM_LOCKS), .AW(LW)) u_lock_ram (
		.clk(clk), .we(lwe), .waddr(lidx_q), .wdata(lwdata_w),
		.re(lre), .raddr(lraddr), .rdata(lrdata)
	);

	rwlt_ram #(.WIDTH(rwlt_pkg::PROC_W), .DEPTH(NUM_PROCS), .AW(PW)) u_proc_ram (
		.clk(clk), .we(pwe), .waddr(pwaddr), .wdata(pwdata),
		.re(pre), .raddr(praddr), .rdata(prdata)
	);

	assign lk_rd = rwlt_pkg::lock_t'(lrdata);
	// never-written process entries read as no role
	assign pr_eff = prv_s1 ? rwlt_pkg::proc_t'(prdata) : '0;
	assign lwdata_w = lwdata;

	logic out_free;
	assign out_free = !ov_q || m_tready;
	assign s_tready = (state_q == S_IDLE);

	// decode of the fetched entries
	logic bad, inuse, is_try, is_wr, wait_c, q_room, wr_first, wake_go;
	logic [1:0] new_role;
	logic [4:0] wc_dec;
	assign bad = (func_q > rwlt_pkg::FN_REL) || !lid_ok_q || !(32'(pid_q) < NUM_PROCS);
	assign inuse = in_use_q[lidx_q];
	assign is_try = (func_q == rwlt_pkg::FN_RD) || (func_q == rwlt_pkg::FN_WR);
	assign is_wr = (func_q == rwlt_pkg::FN_WR);
	assign wait_c = is_wr ? ((lk_rd.cnt != 6'sd0) || (lk_rd.wc != 5'd0))
	                      : (lk_rd.cnt[5] || (lk_rd.wc != 5'd0));
	assign q_room = (lk_rd.wc < 5'(QCAP));
	assign new_role = is_wr ? rwlt_pkg::ROLE_WRITE : rwlt_pkg::ROLE_READ;
	assign wr_first = first_q && (pr_eff.role == rwlt_pkg::ROLE_WRITE);
	assign wake_go = !wr_first && (lk_q.wc != 5'd0) && (pr_eff.role == rwlt_pkg::ROLE_READ);
	assign wc_dec = lk_q.wc - 5'd1;

	always_comb begin
		lre = 1'b0;
		lraddr = LW'(s_tdata[3:0]);
		pre = 1'b0;
		praddr = PW'(s_tdata[7:4]);
		pwe = 1'b0;
		pwaddr = PW'(pid_q);
		pwdata = pr_eff;
		lwe = 1'b0;
		lwdata = lk_q;
		if (func_q == rwlt_pkg::FN_DEL || func_q == rwlt_pkg::FN_RST) begin
			lwdata.wc = 5'd0;
			lwdata.cnt = (func_q == rwlt_pkg::FN_DEL) ? 6'sd0 : $signed({1'b0, ic_q});
		end
		case (state_q)
			S_IDLE: begin
				if (s_tvalid && s_tuser != rwlt_pkg::FN_CREATE) begin
					lre = 1'b1;
					pre = 1'b1;
				end
			end
			S_RD: begin
				if (!bad && func_q == rwlt_pkg::FN_REL) begin
					pwe = 1'b1;
					pwdata.role = rwlt_pkg::ROLE_NONE;
				end else if (!bad && inuse && is_try && (!wait_c || q_room)) begin
					pwe = 1'b1;
					pwdata.role = new_role;
					// joining behind itself links to itself
					if (wait_c && lk_rd.wc != 5'd0 && lk_rd.tail == pid_q) begin
						pwdata.nxt = pid_q;
					end
				end
			end
			S_ENQ_RD: begin
				pre = 1'b1;
				praddr = PW'(otail_q);
			end
			S_ENQ_WR: begin
				pwe = 1'b1;
				pwaddr = PW'(otail_q);
				pwdata.nxt = pid_q;
			end
			S_HD_RD: begin
				pre = 1'b1;
				praddr = PW'(lk_q.head);
			end
			S_WAKE: begin
				if (out_free && wake_go && lk_q.wc > 5'd1) begin
					pre = 1'b1;
					praddr = PW'(pr_eff.nxt);
				end
			end
			S_DRAIN: begin
				if (out_free) begin
					pwe = 1'b1;
					pwaddr = PW'(lk_q.head);
					pwdata.role = rwlt_pkg::ROLE_NONE;
					if (lk_q.wc > 5'd1) begin
						pre = 1'b1;
						praddr = PW'(pr_eff.nxt);
					end
				end
			end
			S_FIN: begin
				lwe = out_free && lkwr_q;
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			in_use_q <= '0;
			pv_q <= '0;
			cur_q <= '0;
			ov_q <= 1'b0;
			prv_s1 <= 1'b0;
		end else begin
			if (pwe) begin
				pv_q[pwaddr] <= 1'b1;
			end
			if (pre) begin
				prv_s1 <= pv_q[praddr];
			end
			if (m_tready) begin
				ov_q <= 1'b0;
			end
			case (state_q)
				S_IDLE: begin
					if (s_tvalid) begin
						func_q <= s_tuser;
						lidx_q <= LW'(s_tdata[3:0]);
						lid_ok_q <= 32'(s_tdata[3:0]) < NUM_LOCKS;
						pid_q <= s_tdata[7:4];
						ic_q <= s_tdata[12:8];
						st_q <= 1'b1;
						gr_q <= rwlt_pkg::GR_NA;
						cid_q <= '0;
						pend_v_q <= 1'b0;
						pend_q <= '0;
						first_q <= 1'b1;
						lkwr_q <= 1'b0;
						scan_q <= '0;
						state_q <= (s_tuser == rwlt_pkg::FN_CREATE) ? S_SCAN : S_RD;
					end
				end
				S_SCAN: begin
					cur_q <= (32'(cur_q) == NUM_LOCKS - 1) ? '0 : cur_q + 1'b1;
					scan_q <= scan_q + 1'b1;
					if (!in_use_q[cur_q]) begin
						lidx_q <= cur_q;
						lk_q <= '{cnt: $signed({1'b0, ic_q}), head: 4'd0, tail: 4'd0, wc: 5'd0};
						cid_q <= 4'(cur_q);
						st_q <= 1'b0;
						lkwr_q <= 1'b1;
						state_q <= S_FIN;
					end else if (32'(scan_q) == NUM_LOCKS - 1) begin
						state_q <= S_FIN;
					end
				end
				S_RD: begin
					lk_q <= lk_rd;
					state_q <= S_FIN;
					if (!bad && inuse) begin
						if (func_q == rwlt_pkg::FN_REL) begin
							st_q <= 1'b0;
							lkwr_q <= 1'b1;
							lk_q.cnt <= rwlt_pkg::cnt_step(lk_rd.cnt,
								pr_eff.role == rwlt_pkg::ROLE_WRITE);
							if (lk_rd.wc != 5'd0) begin
								state_q <= S_HD_RD;
							end
						end else if (func_q == rwlt_pkg::FN_DEL || func_q == rwlt_pkg::FN_RST) begin
							st_q <= 1'b0;
							lkwr_q <= 1'b1;
							if (lk_rd.wc != 5'd0) begin
								state_q <= S_HD_RD;
							end
						end else if (!wait_c) begin
							st_q <= 1'b0;
							gr_q <= rwlt_pkg::GR_ENTER;
							lkwr_q <= 1'b1;
							lk_q.cnt <= rwlt_pkg::cnt_step(lk_rd.cnt, !is_wr);
						end else if (q_room) begin
							st_q <= 1'b0;
							gr_q <= rwlt_pkg::GR_QUEUE;
							lkwr_q <= 1'b1;
							lk_q.head <= (lk_rd.wc == 5'd0) ? pid_q : lk_rd.head;
							lk_q.tail <= pid_q;
							lk_q.wc <= lk_rd.wc + 5'd1;
							otail_q <= lk_rd.tail;
							if (lk_rd.wc != 5'd0 && lk_rd.tail != pid_q) begin
								state_q <= S_ENQ_RD;
							end
						end
					end
				end
				S_ENQ_RD: begin
					state_q <= S_ENQ_WR;
				end
				S_ENQ_WR: begin
					state_q <= S_FIN;
				end
				S_HD_RD: begin
					state_q <= (func_q == rwlt_pkg::FN_REL) ? S_WAKE : S_DRAIN;
				end
				S_WAKE: begin
					if (out_free) begin
						first_q <= 1'b0;
						state_q <= S_FIN;
						if (wr_first) begin
							if (lk_q.cnt == 6'sd0) begin
								pend_v_q <= 1'b1;
								pend_q <= lk_q.head;
								lk_q.wc <= wc_dec;
								if (wc_dec != 5'd0) begin
									lk_q.head <= pr_eff.nxt;
								end
								lk_q.cnt <= rwlt_pkg::cnt_step(lk_q.cnt, 1'b0);
							end
						end else if (wake_go) begin
							// previous wake goes out once another one follows
							if (pend_v_q) begin
								ov_q <= 1'b1;
								od_st_q <= st_q;
								od_gr_q <= gr_q;
								od_cid_q <= cid_q;
								od_wv_q <= 1'b1;
								od_wp_q <= pend_q;
								od_last_q <= 1'b0;
							end
							pend_v_q <= 1'b1;
							pend_q <= lk_q.head;
							lk_q.wc <= wc_dec;
							lk_q.cnt <= rwlt_pkg::cnt_step(lk_q.cnt, 1'b1);
							if (wc_dec != 5'd0) begin
								lk_q.head <= pr_eff.nxt;
								state_q <= S_WAKE;
							end
						end
					end
				end
				S_DRAIN: begin
					if (out_free) begin
						if (pend_v_q) begin
							ov_q <= 1'b1;
							od_st_q <= st_q;
							od_gr_q <= gr_q;
							od_cid_q <= cid_q;
							od_wv_q <= 1'b1;
							od_wp_q <= pend_q;
							od_last_q <= 1'b0;
						end
						pend_v_q <= 1'b1;
						pend_q <= lk_q.head;
						lk_q.wc <= wc_dec;
						if (wc_dec != 5'd0) begin
							lk_q.head <= pr_eff.nxt;
						end else begin
							state_q <= S_FIN;
						end
					end
				end
				S_FIN: begin
					if (out_free) begin
						ov_q <= 1'b1;
						od_st_q <= st_q;
						od_gr_q <= gr_q;
						od_cid_q <= cid_q;
						od_wv_q <= pend_v_q;
						od_wp_q <= pend_v_q ? pend_q : 4'd0;
						od_last_q <= 1'b1;
						if (lkwr_q && func_q == rwlt_pkg::FN_CREATE) begin
							in_use_q[lidx_q] <= 1'b1;
						end
						if (lkwr_q && func_q == rwlt_pkg::FN_DEL) begin
							in_use_q[lidx_q] <= 1'b0;
						end
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	assign m_tvalid = ov_q;
	assign m_tdata = {5'd0, od_wp_q, od_cid_q, od_gr_q, od_st_q};
	assign m_tuser = od_wv_q;
	assign m_tlast = od_last_q;

endmodule

### sv/rwlt_chk.sv
// port-level checker for the reader-writer lock table, bound to the top level
`timescale 1ns / 1ps
module rwlt_chk (
	input logic        clk,
	input logic        arst_n,
	input logic        s_tvalid,
	input logic        s_tready,
	input logic        m_tvalid,
	input logic        m_tready,
	input logic [15:0] m_tdata,
	input logic        m_tuser,
	input logic        m_tlast
);

	// a stalled result holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tlast))
		else $error("result changed while stalled");

	// one operation at a time
	a_busy: assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready |=> !s_tready)
		else $error("input taken while busy");

	// a result naming nobody ends the operation
	a_nowake_last: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tuser |-> m_tlast)
		else $error("no-wake result not last");

	// errors wake nobody
	a_err_single: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tdata[0] |-> m_tlast && !m_tuser)
		else $error("error result with wake");

	// granted try operations give a single result
	a_grant_single: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tdata[2:1] != 2'd0 |-> m_tlast && !m_tuser)
		else $error("granted try with wake");

endmodule

bind reader_writer_lock_table rwlt_chk u_rwlt_chk (.*);

### test/reader_writer_lock_table_test.sv
// stimulus, lock table predictor and result checks for the reader-writer lock table
`timescale 1ns / 1ps
module reader_writer_lock_table_test;

	typedef struct packed {
		logic [0:0] status;
		logic [1:0] grant;
		logic [3:0] cid;
		logic [0:0] wv;
		logic [3:0] wpid;
		logic [0:0] last;
	} res_t;

	typedef struct {
		logic [2:0] fn;
		logic [3:0] lid;
		logic [3:0] pid;
		logic [4:0] ic;
		logic       typed;
		logic       exp_status;
		logic [1:0] exp_grant;
		logic [3:0] exp_cid;
	} row_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic s_tvalid = 1'b0;
	logic s_tready;
	logic [15:0] s_tdata = '0;
	logic [2:0] s_tuser = '0;
	logic m_tvalid;
	logic m_tready = 1'b0;
	logic [15:0] m_tdata;
	logic m_tuser;
	logic m_tlast;

	reader_writer_lock_table dut (
		.clk(clk), .arst_n(arst_n),
		.s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
		.m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser),
		.m_tlast(m_tlast)
	);

	// predictor state
	logic              in_use [16];
	logic signed [5:0] cnt    [16];
	logic [3:0]        qhead  [16];
	logic [3:0]        qtail  [16];
	logic [4:0]        waiters[16];
	logic [3:0]        nxt    [16];
	logic [1:0]        role   [16];
	logic [3:0]        cursor;

	res_t pending_results[$];
	int errors = 0;
	int cycles = 0;
	bit stim_done = 0;
	int hold_off = 0;

	initial begin
		forever #6 clk = ~clk;
	end

	always @(posedge clk) cycles <= cycles + 1;

	function automatic logic signed [5:0] sat_add(logic signed [5:0] c, int d);
		int v;
		v = int'(c) + d;
		if (v > 31) v = 31;
		if (v < -32) v = -32;
		return v[5:0];
	endfunction

	function automatic logic [3:0] pop_waiter(logic [3:0] l);
		logic [3:0] p;
		p = qhead[l];
		waiters[l] = waiters[l] - 5'd1;
		if (waiters[l] > 0) qhead[l] = nxt[p];
		return p;
	endfunction

	task automatic predict_op(input logic [2:0] fn, input logic [3:0] l, input logic [3:0] p,
			input logic [4:0] ic, output res_t first_r);
		logic st;
		logic [1:0] gr, mine;
		logic [3:0] cid, w, c;
		logic [3:0] woken[$];
		logic wr, wt;
		res_t r;
		st = 1'b1; gr = rwlt_pkg::GR_NA; cid = 4'd0;
		if (fn == rwlt_pkg::FN_CREATE) begin
			for (int i = 0; i < 16; i++) begin
				c = cursor;
				cursor = cursor + 4'd1;
				if (!in_use[c]) begin
					in_use[c] = 1'b1; cnt[c] = $signed({1'b0, ic});
					waiters[c] = 5'd0; qhead[c] = 4'd0; qtail[c] = 4'd0;
					st = 1'b0; cid = c;
					break;
				end
			end
		end else if (fn == rwlt_pkg::FN_REL) begin
			mine = role[p];
			role[p] = rwlt_pkg::ROLE_NONE;
			if (in_use[l]) begin
				st = 1'b0;
				cnt[l] = sat_add(cnt[l], mine == rwlt_pkg::ROLE_WRITE ? 1 : -1);
				if (waiters[l] > 0) begin
					if (role[qhead[l]] == rwlt_pkg::ROLE_WRITE) begin
						if (cnt[l] == 0) begin
							woken.push_back(pop_waiter(l));
							cnt[l] = sat_add(cnt[l], -1);
						end
					end else begin
						while (waiters[l] > 0 && woken.size() < 16 &&
								role[qhead[l]] == rwlt_pkg::ROLE_READ) begin
							woken.push_back(pop_waiter(l));
							cnt[l] = sat_add(cnt[l], 1);
						end
					end
				end
			end
		end else if (fn <= rwlt_pkg::FN_REL && in_use[l]) begin
			if (fn == rwlt_pkg::FN_DEL || fn == rwlt_pkg::FN_RST) begin
				st = 1'b0;
				while (waiters[l] > 0 && woken.size() < 16) begin
					w = pop_waiter(l);
					role[w] = rwlt_pkg::ROLE_NONE;
					woken.push_back(w);
				end
				waiters[l] = 5'd0;
				if (fn == rwlt_pkg::FN_DEL) begin
					in_use[l] = 1'b0; cnt[l] = 6'sd0;
				end else begin
					cnt[l] = $signed({1'b0, ic});
				end
			end else begin
				wr = (fn == rwlt_pkg::FN_WR);
				wt = wr ? (cnt[l] != 0 || waiters[l] > 0) : (cnt[l] < 0 || waiters[l] > 0);
				if (!wt) begin
					role[p] = wr ? rwlt_pkg::ROLE_WRITE : rwlt_pkg::ROLE_READ;
					cnt[l] = sat_add(cnt[l], wr ? -1 : 1);
					st = 1'b0; gr = rwlt_pkg::GR_ENTER;
				end else if (waiters[l] < 16) begin
					role[p] = wr ? rwlt_pkg::ROLE_WRITE : rwlt_pkg::ROLE_READ;
					if (waiters[l] == 0) qhead[l] = p;
					else nxt[qtail[l]] = p;
					qtail[l] = p;
					waiters[l] = waiters[l] + 5'd1;
					st = 1'b0; gr = rwlt_pkg::GR_QUEUE;
				end
			end
		end
		if (woken.size() == 0) begin
			r = '{st, gr, cid, 1'b0, 4'd0, 1'b1};
			first_r = r;
			pending_results.push_back(r);
		end else begin
			foreach (woken[k]) begin
				r = '{st, gr, cid, 1'b1, woken[k], k == woken.size() - 1};
				if (k == 0) first_r = r;
				pending_results.push_back(r);
			end
		end
	endtask

	// valid stays up across a zero gap so it never gets two updates in one step
	task automatic send_op(input logic [2:0] fn, input logic [3:0] l, input logic [3:0] p,
			input logic [4:0] ic, output res_t first_r);
		int gap;
		gap = $urandom_range(0, 15);
		if (gap != 0) begin
			s_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		predict_op(fn, l, p, ic, first_r);
		s_tvalid <= 1'b1;
		s_tuser <= fn;
		s_tdata <= {3'd0, ic, p, l};
		do @(posedge clk); while (!s_tready);
	endtask

	// receiver
	initial begin
		res_t got, want;
		int gap_left;
		gap_left = 0;
		forever begin
			@(posedge clk);
			if (m_tvalid && m_tready) begin
				got = '{m_tdata[0], m_tdata[2:1], m_tdata[6:3], m_tuser, m_tdata[10:7],
					m_tlast};
				gap_left = $urandom_range(0, 15);
				if (pending_results.size() == 0) begin
					$display("%0t unexpected result, expected none, actual %h", $time, got);
					errors++;
				end else begin
					want = pending_results.pop_front();
					if (got !== want) begin
						$display({"%0t mismatch expected st=%0d gr=%0d cid=%0d wv=%0d wp=%0d",
							" l=%0d actual st=%0d gr=%0d cid=%0d wv=%0d wp=%0d l=%0d"},
							$time, want.status, want.grant, want.cid, want.wv, want.wpid,
							want.last, got.status, got.grant, got.cid, got.wv, got.wpid,
							got.last);
						errors++;
					end
				end
			end else if (gap_left > 0) begin
				gap_left--;
			end
			if (hold_off > 0) begin
				hold_off <= hold_off - 1;
				m_tready <= 1'b0;
			end else begin
				m_tready <= (gap_left == 0);
			end
		end
	end

	// directed rows: typed expectations where obvious, predictor otherwise
	row_t rows[$];
	initial begin
		rows.push_back('{rwlt_pkg::FN_RD,  4'd0,  4'd0,  5'd0,  1, 1, rwlt_pkg::GR_NA, 4'd0});
		rows.push_back('{rwlt_pkg::FN_REL, 4'd15, 4'd15, 5'd0,  1, 1, rwlt_pkg::GR_NA, 4'd0});
		rows.push_back('{rwlt_pkg::FN_DEL, 4'd3,  4'd0,  5'd0,  1, 1, rwlt_pkg::GR_NA, 4'd0});
		// unknown func
		rows.push_back('{3'd6, 4'd0,  4'd0,  5'd0,  1, 1, rwlt_pkg::GR_NA, 4'd0});
		rows.push_back('{3'd7, 4'd15, 4'd15, 5'd31, 1, 1, rwlt_pkg::GR_NA, 4'd0});
		rows.push_back('{rwlt_pkg::FN_CREATE, 4'd0, 4'd0, 5'd0,  1, 0, rwlt_pkg::GR_NA, 4'd0});
		rows.push_back('{rwlt_pkg::FN_CREATE, 4'd9, 4'd5, 5'd16, 1, 0, rwlt_pkg::GR_NA, 4'd1});
		rows.push_back('{rwlt_pkg::FN_WR,  4'd0, 4'd1,  5'd0,  1, 0, rwlt_pkg::GR_ENTER, 4'd0});
		rows.push_back('{rwlt_pkg::FN_RD,  4'd0, 4'd2,  5'd0,  0, 0, rwlt_pkg::GR_NA, 4'd0});
		rows.push_back('{rwlt_pkg::FN_RD,  4'd0, 4'd3,  5'd0,  0, 0, rwlt_pkg::GR_NA, 4'd0});
		rows.push_back('{rwlt_pkg::FN_WR,  4'd0, 4'd4,  5'd0,  0, 0, rwlt_pkg::GR_NA, 4'd0});
		// run of readers
		rows.push_back('{rwlt_pkg::FN_REL, 4'd0, 4'd1,  5'd0,  0, 0, rwlt_pkg::GR_NA, 4'd0});
		rows.push_back('{rwlt_pkg::FN_REL, 4'd0, 4'd2,  5'd0,  0, 0, rwlt_pkg::GR_NA, 4'd0});
		// writer woken
		rows.push_back('{rwlt_pkg::FN_REL, 4'd0, 4'd3,  5'd0,  0, 0, rwlt_pkg::GR_NA, 4'd0});
		// count at 16
		rows.push_back('{rwlt_pkg::FN_RD,  4'd1, 4'd6,  5'd0,  0, 0, rwlt_pkg::GR_NA, 4'd0});
		rows.push_back('{rwlt_pkg::FN_WR,  4'd1, 4'd7,  5'd0,  0, 0, rwlt_pkg::GR_NA, 4'd0});
		rows.push_back('{rwlt_pkg::FN_RD,  4'd1, 4'd8,  5'd0,  0, 0, rwlt_pkg::GR_NA, 4'd0});
		// reset drains
		rows.push_back('{rwlt_pkg::FN_RST, 4'd1, 4'd0,  5'd31, 0, 0, rwlt_pkg::GR_NA, 4'd0});
		// saturates at 31
		rows.push_back('{rwlt_pkg::FN_RD,  4'd1, 4'd9,  5'd0,  0, 0, rwlt_pkg::GR_NA, 4'd0});
		// roleless release
		rows.push_back('{rwlt_pkg::FN_REL, 4'd1, 4'd10, 5'd0,  0, 0, rwlt_pkg::GR_NA, 4'd0});
		rows.push_back('{rwlt_pkg::FN_DEL, 4'd0, 4'd0,  5'd0,  0, 0, rwlt_pkg::GR_NA, 4'd0});
		rows.push_back('{rwlt_pkg::FN_DEL, 4'd1, 4'd0,  5'd0,  0, 0, rwlt_pkg::GR_NA, 4'd0});
	end

	initial begin
		logic [2:0] fn;
		logic [3:0] l, p;
		int n;
		res_t fr;
		foreach (in_use[i]) begin
			in_use[i] = 1'b0; cnt[i] = 6'sd0; qhead[i] = 4'd0; qtail[i] = 4'd0;
			waiters[i] = 5'd0; nxt[i] = 4'd0; role[i] = rwlt_pkg::ROLE_NONE;
		end
		cursor = 4'd0;
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		foreach (rows[i]) begin
			send_op(rows[i].fn, rows[i].lid, rows[i].pid, rows[i].ic, fr);
			if (rows[i].typed && (fr.status !== rows[i].exp_status ||
					fr.grant !== rows[i].exp_grant || fr.cid !== rows[i].exp_cid)) begin
				$display("%0t table row %0d expected st=%0d gr=%0d cid=%0d actual st=%0d gr=%0d cid=%0d",
					$time, i, rows[i].exp_status, rows[i].exp_grant, rows[i].exp_cid,
					fr.status, fr.grant, fr.cid);
				errors++;
			end
		end
		// fill all slots, so create reports no free lock
		for (int i = 0; i < 17; i++) begin
			send_op(rwlt_pkg::FN_CREATE, 4'($urandom), 4'($urandom),
				5'($urandom_range(0, 16)), fr);
		end
		// long receiver stall while ops keep coming
		hold_off = 300;
		for (int i = 0; i < 20; i++) begin
			l = 4'($urandom_range(0, 3));
			p = 4'($urandom);
			send_op($urandom_range(0, 1) ? rwlt_pkg::FN_RD : rwlt_pkg::FN_WR, l, p, 5'd0, fr);
		end
		// random: mostly try/release on few locks, some lifecycle and noise
		for (int i = 0; i < 60; i++) begin
			n = $urandom_range(0, 99);
			if (n < 35) fn = rwlt_pkg::FN_RD;
			else if (n < 55) fn = rwlt_pkg::FN_WR;
			else if (n < 85) fn = rwlt_pkg::FN_REL;
			else if (n < 90) fn = rwlt_pkg::FN_CREATE;
			else if (n < 94) fn = rwlt_pkg::FN_DEL;
			else if (n < 98) fn = rwlt_pkg::FN_RST;
			else fn = 3'($urandom_range(6, 7));
			l = ($urandom_range(0, 3) == 0) ? 4'($urandom) : 4'($urandom_range(0, 3));
			p = 4'($urandom);
			if (fn == rwlt_pkg::FN_REL && $urandom_range(0, 1)) begin
				for (int q = 0; q < 16; q++) begin
					if (role[q] != rwlt_pkg::ROLE_NONE) begin
						p = 4'(q);
						break;
					end
				end
			end
			send_op(fn, l, p, 5'($urandom_range(0, 16)), fr);
		end
		s_tvalid <= 1'b0;
		stim_done = 1;
	end

	initial begin
		wait (stim_done && pending_results.size() == 0);
		repeat (40) @(posedge clk);
		if (errors == 0 && pending_results.size() == 0) begin
			$display("RESULT: OK");
		end else begin
			$display("RESULT: ERROR");
		end
		$finish;
	end

	initial begin
		wait (cycles >= 200000);
		$display("RESULT: ERROR");
		$finish;
	end
endmodule
